// ----- rtl/core/wcdd_pkg.sv -----
// Package for the weighted cepstral delta distance core: sizes, codes,
// shared structs and the store address function. No dependencies.
`timescale 1ns / 1ps

package wcdd_pkg;

	localparam int MAX_FRAMES      = 256;
	localparam int NUM_COEFFS      = 12;
	localparam int MAX_HALF_WINDOW = 4;

	localparam int ROW_LEN     = NUM_COEFFS + 1;
	localparam int STORE_DEPTH = MAX_FRAMES * ROW_LEN;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int ROWIDX_W    = $clog2(MAX_FRAMES);

	localparam int FRAME_W = 9;
	localparam int COEF_W  = 4;
	localparam int VAL_W   = 16;
	localparam int WGT_W   = 16;
	localparam int HALF_W  = 3;
	localparam int DIST_W  = 16;

	localparam int J_W    = $clog2(MAX_HALF_WINDOW + 1) + 1;
	localparam int SUM_W  = VAL_W + $clog2(MAX_HALF_WINDOW * (MAX_HALF_WINDOW + 1)) + 1;
	localparam int P_W    = SUM_W + WGT_W + 1;
	localparam int DIFF_W = VAL_W + 1;
	localparam int SQ_W   = 2 * VAL_W;
	localparam int S_W    = SQ_W + $clog2(NUM_COEFFS + 1);
	localparam int PROD_W = S_W + WGT_W;
	localparam int NUM_W  = PROD_W + 2;
	localparam int WSUM_W = WGT_W + 2;
	localparam int QUO_W  = NUM_W - 8;
	localparam int ROOT_W = (QUO_W + 1) / 2;
	localparam int SQX_W  = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 3;
	localparam int STEP_W = $clog2(QUO_W + 1);

	typedef enum logic [1:0] {
		KIND_LOAD_A = 2'd0,
		KIND_LOAD_B = 2'd1,
		KIND_QUERY  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		CFG_W_CEP          = 3'd0,
		CFG_W_ENERGY       = 3'd1,
		CFG_W_DELTA        = 3'd2,
		CFG_W_DELTA_ENERGY = 3'd3,
		CFG_HALF_WINDOW    = 3'd4,
		CFG_FRAMES_A       = 3'd5,
		CFG_FRAMES_B       = 3'd6,
		CFG_DELTA_SCALE    = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [WGT_W-1:0]   w_cep;
		logic [WGT_W-1:0]   w_energy;
		logic [WGT_W-1:0]   w_delta;
		logic [WGT_W-1:0]   w_delta_energy;
		logic [HALF_W-1:0]  half;
		logic [FRAME_W-1:0] na;
		logic [FRAME_W-1:0] nb;
		logic [WGT_W-1:0]   scale;
	} cfg_t;

	typedef struct packed {
		logic                  accept;
		logic                  start;
		logic                  issue;
		logic [COEF_W-1:0]     k;
		logic signed [J_W-1:0] j;
		logic                  first;
		logic                  last;
		logic                  mul;
		logic                  sum;
		logic                  div_step;
		logic                  sq_init;
		logic                  sq_step;
		logic                  load_out;
	} cmd_t;

	typedef struct packed {
		logic query_ok;
		logic pipe_busy;
		logic out_valid;
	} sts_t;

	// Store address of coefficient k of frame f+j; frames off the store map to row 0.
	function automatic logic [ADDR_W-1:0] coef_addr(input logic [FRAME_W-1:0] f,
			input logic signed [J_W-1:0] j, input logic [COEF_W-1:0] k);
		logic signed [FRAME_W+1:0] sel;
		logic [ROWIDX_W-1:0]       row;
		sel = $signed({2'b00, f}) + $signed({{(FRAME_W + 2 - J_W){j[J_W-1]}}, j});
		if (sel < 1 || sel > MAX_FRAMES) begin
			row = '0;
		end else begin
			row = ROWIDX_W'(sel - 1);
		end
		return ADDR_W'(ADDR_W'(row) * ADDR_W'(ROW_LEN) + ADDR_W'(k));
	endfunction

endpackage

// ----- rtl/core/wcdd_ram.sv -----
// Generic single write, single read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module wcdd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/wcdd_datapath.sv -----
// Datapath: coefficient stores, regression pipeline, weighted sums,
// divider, square root and output register. Uses wcdd_pkg and wcdd_ram.
`timescale 1ns / 1ps

module wcdd_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  wcdd_pkg::cfg_t                    cfg,
	input  wcdd_pkg::cmd_t                    cmd,
	output wcdd_pkg::sts_t                    sts,
	input  logic [1:0]                        kind,
	input  logic [wcdd_pkg::FRAME_W-1:0]      frame_index,
	input  logic [wcdd_pkg::COEF_W-1:0]       coef_index,
	input  logic signed [wcdd_pkg::VAL_W-1:0] coef_value,
	input  logic [wcdd_pkg::FRAME_W-1:0]      other_frame_index,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [wcdd_pkg::DIST_W-1:0]       distance,
	output logic                              weight_error,
	output logic [wcdd_pkg::FRAME_W-1:0]      row_index,
	output logic [wcdd_pkg::FRAME_W-1:0]      col_index
);

	localparam int FW = wcdd_pkg::FRAME_W;
	localparam int VW = wcdd_pkg::VAL_W;
	localparam int JW = wcdd_pkg::J_W;

	function automatic logic signed [VW-1:0] round_sat(input logic signed [wcdd_pkg::P_W-1:0] p);
		logic                        neg;
		logic [wcdd_pkg::P_W-1:0]    mag;
		logic [wcdd_pkg::P_W:0]      rnd;
		logic [wcdd_pkg::P_W-16:0]   r;
		neg = p[wcdd_pkg::P_W-1];
		mag = neg ? wcdd_pkg::P_W'(-p) : wcdd_pkg::P_W'(p);
		rnd = {1'b0, mag} + (wcdd_pkg::P_W + 1)'(32768);
		r   = rnd[wcdd_pkg::P_W:16];
		if (neg) begin
			return (r > 32768) ? VW'(-32768) : VW'(-$signed({1'b0, r}));
		end
		return (r > 32767) ? VW'(32767) : VW'(r);
	endfunction

	// Stores
	logic                          load_ok, we_a, we_b;
	logic [wcdd_pkg::ADDR_W-1:0]   waddr, raddr_a, raddr_b;
	logic [VW-1:0]                 rd_a, rd_b;

	// Query context
	logic [FW-1:0] fa_q, fb_q;
	logic          za_q, zb_q, za, zb;
	logic [wcdd_pkg::WSUM_W-1:0] wsum;

	assign load_ok = frame_index >= FW'(1) && frame_index <= FW'(wcdd_pkg::MAX_FRAMES)
		&& coef_index <= wcdd_pkg::COEF_W'(wcdd_pkg::NUM_COEFFS);
	assign we_a  = cmd.accept && kind == wcdd_pkg::KIND_LOAD_A && load_ok;
	assign we_b  = cmd.accept && kind == wcdd_pkg::KIND_LOAD_B && load_ok;
	assign waddr = wcdd_pkg::coef_addr(frame_index, JW'(0), coef_index);
	assign raddr_a = wcdd_pkg::coef_addr(fa_q, cmd.j, cmd.k);
	assign raddr_b = wcdd_pkg::coef_addr(fb_q, cmd.j, cmd.k);

	wcdd_ram #(.WIDTH(VW), .DEPTH(wcdd_pkg::STORE_DEPTH)) u_ram_a (
		.clk(clk), .we(we_a), .waddr(waddr), .wdata(coef_value),
		.raddr(raddr_a), .rdata(rd_a)
	);

	wcdd_ram #(.WIDTH(VW), .DEPTH(wcdd_pkg::STORE_DEPTH)) u_ram_b (
		.clk(clk), .we(we_b), .waddr(waddr), .wdata(coef_value),
		.raddr(raddr_b), .rdata(rd_b)
	);

	assign sts.query_ok = kind == wcdd_pkg::KIND_QUERY
		&& frame_index >= FW'(1) && frame_index <= cfg.na
		&& other_frame_index >= FW'(1) && other_frame_index <= cfg.nb;

	// Delta is forced to zero near either end of the sequence
	always_comb begin
		logic signed [FW+1:0] h, fa, fb, na, nb;
		h  = $signed({{(FW + 2 - wcdd_pkg::HALF_W){1'b0}}, cfg.half});
		fa = $signed({2'b00, frame_index});
		fb = $signed({2'b00, other_frame_index});
		na = $signed({2'b00, cfg.na});
		nb = $signed({2'b00, cfg.nb});
		za = fa <= h || fa >= na - h;
		zb = fb <= h || fb >= nb - h;
	end

	assign wsum = wcdd_pkg::WSUM_W'(cfg.w_cep) + wcdd_pkg::WSUM_W'(cfg.w_energy)
		+ wcdd_pkg::WSUM_W'(cfg.w_delta) + wcdd_pkg::WSUM_W'(cfg.w_delta_energy);

	// Pipeline registers
	logic                              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [JW-1:0]              j_s1;
	logic                              first_s1, last_s1, k0_s1, k0_s2, k0_s3, k0_s4, k0_s5;
	logic signed [wcdd_pkg::SUM_W-1:0] acc_a_q, acc_b_q, acc_nx_a, acc_nx_b;
	logic signed [VW-1:0]              raw_a_q, raw_b_q;
	logic signed [wcdd_pkg::SUM_W-1:0] sum_a_s2, sum_b_s2;
	logic signed [VW-1:0]              raw_a_s2, raw_b_s2, raw_a_s3, raw_b_s3;
	logic signed [wcdd_pkg::P_W-1:0]   p_a_s3, p_b_s3;
	logic signed [wcdd_pkg::DIFF_W-1:0] cdiff_s4, ddiff_s4;
	logic [wcdd_pkg::SQ_W-1:0]         sq_c_s5, sq_d_s5;
	logic signed [VW+JW-1:0]           prod_a, prod_b;
	logic signed [VW-1:0]              d_a, d_b;
	logic signed [2*wcdd_pkg::DIFF_W-1:0] sq_c, sq_d;

	assign prod_a   = $signed(rd_a) * j_s1;
	assign prod_b   = $signed(rd_b) * j_s1;
	assign acc_nx_a = (first_s1 ? '0 : acc_a_q) + wcdd_pkg::SUM_W'(prod_a);
	assign acc_nx_b = (first_s1 ? '0 : acc_b_q) + wcdd_pkg::SUM_W'(prod_b);
	assign d_a      = za_q ? '0 : round_sat(p_a_s3);
	assign d_b      = zb_q ? '0 : round_sat(p_b_s3);
	assign sq_c     = cdiff_s4 * cdiff_s4;
	assign sq_d     = ddiff_s4 * ddiff_s4;

	// Group sums, products, divider and root
	logic [wcdd_pkg::S_W-1:0]    s_cep_q, s_del_q;
	logic [wcdd_pkg::SQ_W-1:0]   s_en_q, s_den_q;
	logic [wcdd_pkg::PROD_W-1:0] pc_q, pe_q, pd_q, pde_q;
	logic [wcdd_pkg::NUM_W-1:0]  num;
	logic [wcdd_pkg::QUO_W-1:0]  dq_q;
	logic [wcdd_pkg::WSUM_W-1:0] rem_q;
	logic [wcdd_pkg::WSUM_W:0]   rem_sh;
	logic                        div_ge;
	logic [wcdd_pkg::SQX_W-1:0]  sx_q;
	logic [wcdd_pkg::REM_W-1:0]  srem_q, srem_sh, trial;
	logic [wcdd_pkg::ROOT_W-1:0] root_q;
	logic                        sq_ge;
	logic                        out_valid_q;

	assign num = wcdd_pkg::NUM_W'(pc_q) + wcdd_pkg::NUM_W'(pe_q)
		+ wcdd_pkg::NUM_W'(pd_q) + wcdd_pkg::NUM_W'(pde_q);
	assign rem_sh  = {rem_q, dq_q[wcdd_pkg::QUO_W-1]};
	assign div_ge  = rem_sh >= {1'b0, wsum};
	assign srem_sh = {srem_q[wcdd_pkg::REM_W-3:0], sx_q[wcdd_pkg::SQX_W-1 -: 2]};
	assign trial   = wcdd_pkg::REM_W'({root_q, 2'b01});
	assign sq_ge   = srem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1 && last_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			fa_q    <= frame_index;
			fb_q    <= other_frame_index;
			za_q    <= za;
			zb_q    <= zb;
			s_cep_q <= '0;
			s_del_q <= '0;
			s_en_q  <= '0;
			s_den_q <= '0;
		end else if (v_s5) begin
			if (k0_s5) begin
				s_en_q  <= sq_c_s5;
				s_den_q <= sq_d_s5;
			end else begin
				s_cep_q <= s_cep_q + wcdd_pkg::S_W'(sq_c_s5);
				s_del_q <= s_del_q + wcdd_pkg::S_W'(sq_d_s5);
			end
		end
		j_s1     <= cmd.j;
		first_s1 <= cmd.first;
		last_s1  <= cmd.last;
		k0_s1    <= cmd.k == '0;
		if (v_s1) begin
			acc_a_q <= acc_nx_a;
			acc_b_q <= acc_nx_b;
			if (j_s1 == '0) begin
				raw_a_q <= rd_a;
				raw_b_q <= rd_b;
			end
		end
		sum_a_s2 <= acc_nx_a;
		sum_b_s2 <= acc_nx_b;
		raw_a_s2 <= (j_s1 == '0) ? rd_a : raw_a_q;
		raw_b_s2 <= (j_s1 == '0) ? rd_b : raw_b_q;
		k0_s2    <= k0_s1;
		p_a_s3   <= sum_a_s2 * $signed({1'b0, cfg.scale});
		p_b_s3   <= sum_b_s2 * $signed({1'b0, cfg.scale});
		raw_a_s3 <= raw_a_s2;
		raw_b_s3 <= raw_b_s2;
		k0_s3    <= k0_s2;
		cdiff_s4 <= wcdd_pkg::DIFF_W'(raw_a_s3) - wcdd_pkg::DIFF_W'(raw_b_s3);
		ddiff_s4 <= wcdd_pkg::DIFF_W'(d_a) - wcdd_pkg::DIFF_W'(d_b);
		k0_s4    <= k0_s3;
		sq_c_s5  <= sq_c[wcdd_pkg::SQ_W-1:0];
		sq_d_s5  <= sq_d[wcdd_pkg::SQ_W-1:0];
		k0_s5    <= k0_s4;

		if (cmd.mul) begin
			pc_q  <= wcdd_pkg::PROD_W'(cfg.w_cep * s_cep_q);
			pe_q  <= wcdd_pkg::PROD_W'(cfg.w_energy * s_en_q);
			pd_q  <= wcdd_pkg::PROD_W'(cfg.w_delta * s_del_q);
			pde_q <= wcdd_pkg::PROD_W'(cfg.w_delta_energy * s_den_q);
		end
		if (cmd.sum) begin
			dq_q  <= num[wcdd_pkg::NUM_W-1:8];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dq_q  <= {dq_q[wcdd_pkg::QUO_W-2:0], div_ge};
			rem_q <= div_ge ? wcdd_pkg::WSUM_W'(rem_sh - {1'b0, wsum})
				: rem_sh[wcdd_pkg::WSUM_W-1:0];
		end
		if (cmd.sq_init) begin
			sx_q   <= wcdd_pkg::SQX_W'(dq_q);
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.sq_step) begin
			sx_q   <= {sx_q[wcdd_pkg::SQX_W-3:0], 2'b00};
			srem_q <= sq_ge ? srem_sh - trial : srem_sh;
			root_q <= {root_q[wcdd_pkg::ROOT_W-2:0], sq_ge};
		end
		if (cmd.load_out) begin
			weight_error <= wsum == '0;
			if (wsum == '0) begin
				distance <= '0;
			end else if (root_q > wcdd_pkg::ROOT_W'(16'hFFFF)) begin
				distance <= 16'hFFFF;
			end else begin
				distance <= root_q[wcdd_pkg::DIST_W-1:0];
			end
			row_index <= fa_q;
			col_index <= fb_q;
		end
	end

	assign sts.pipe_busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s5;
	assign sts.out_valid = out_valid_q;
	assign out_valid     = out_valid_q;

endmodule

// ----- rtl/core/wcdd_ctrl.sv -----
// Controller: sequences window reads, drain, weighting, division and root.
// Uses wcdd_pkg.
`timescale 1ns / 1ps

module wcdd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  wcdd_pkg::cfg_t cfg,
	input  logic           in_valid,
	output logic           in_stall,
	input  wcdd_pkg::sts_t sts,
	output wcdd_pkg::cmd_t cmd
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_READ  = 9'b000000010,
		ST_DRAIN = 9'b000000100,
		ST_MUL   = 9'b000001000,
		ST_SUM   = 9'b000010000,
		ST_DIV   = 9'b000100000,
		ST_SQI   = 9'b001000000,
		ST_SQRT  = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t                              state_q, state_d;
	logic [wcdd_pkg::COEF_W-1:0]         k_q, k_d;
	logic signed [wcdd_pkg::J_W-1:0]     j_q, j_d, hpos;
	logic [wcdd_pkg::STEP_W-1:0]         step_q, step_d;

	assign hpos = $signed({{(wcdd_pkg::J_W - wcdd_pkg::HALF_W){1'b0}}, cfg.half});

	always_comb begin
		state_d      = state_q;
		k_d          = k_q;
		j_d          = j_q;
		step_d       = step_q;
		cmd          = '0;
		cmd.k        = k_q;
		cmd.j        = j_q;
		cmd.first    = j_q == -hpos;
		cmd.last     = j_q == hpos;
		in_stall     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
				if (in_valid && sts.query_ok) begin
					cmd.start = 1'b1;
					k_d       = '0;
					j_d       = -hpos;
					state_d   = ST_READ;
				end
			end
			ST_READ: begin
				cmd.issue = 1'b1;
				if (j_q == hpos) begin
					j_d = -hpos;
					if (k_q == wcdd_pkg::COEF_W'(wcdd_pkg::NUM_COEFFS)) begin
						state_d = ST_DRAIN;
					end else begin
						k_d = k_q + 1'b1;
					end
				end else begin
					j_d = j_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				step_d  = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				step_d       = step_q + 1'b1;
				if (step_q == wcdd_pkg::STEP_W'(wcdd_pkg::QUO_W - 1)) begin
					state_d = ST_SQI;
				end
			end
			ST_SQI: begin
				cmd.sq_init = 1'b1;
				step_d      = '0;
				state_d     = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sq_step = 1'b1;
				step_d      = step_q + 1'b1;
				if (step_q == wcdd_pkg::STEP_W'(wcdd_pkg::ROOT_W - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!sts.out_valid) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			j_q     <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			j_q     <= j_d;
			step_q  <= step_d;
		end
	end

`ifndef SYNTHESIS
	a_ready_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !sts.pipe_busy)
		else $error("request taken while regression pipeline busy");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !sts.out_valid)
		else $error("result overwrites one not yet taken");
	a_out_set: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> sts.out_valid)
		else $error("result register not set after load");
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SUM |=> state_q == ST_DIV && step_q == '0)
		else $error("divider entered with stale step count");
`endif

endmodule

// ----- rtl/core/weighted_cepstral_delta_distance_core.sv -----
// Top level of the weighted cepstral delta distance core: configuration
// registers, controller and datapath. Uses wcdd_pkg, wcdd_ctrl, wcdd_datapath.
`timescale 1ns / 1ps

// Loads (kind 0 and 1) write one Q3.12 coefficient into store A or B and
// leave the block idle; a load with a bad frame or coefficient number is dropped.
// A query (kind 2) returns one Q8.8 distance with the echoed frame numbers;
// a query naming a frame outside the configured sequence length is dropped.
// A query reads both stores in parallel, once per coefficient and window
// tap, then drains the regression pipeline, weights the sums, adds them,
// runs the bit-serial divider, loads the root unit, runs the square root
// and loads the result register; the block is idle again in the cycle in
// which the result becomes valid. A result not yet taken holds the
// finished query in its last step until the output register frees up.
// The block takes no request while a query is in progress; a finished
// result waits in the output register while the next request is taken.
// The stores are not cleared at reset; read only frames that were loaded.
// Write configuration only while the block is idle.

module weighted_cepstral_delta_distance_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        kind,
	input  logic [wcdd_pkg::FRAME_W-1:0]      frame_index,
	input  logic [wcdd_pkg::COEF_W-1:0]       coef_index,
	input  logic signed [wcdd_pkg::VAL_W-1:0] coef_value,
	input  logic [wcdd_pkg::FRAME_W-1:0]      other_frame_index,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [wcdd_pkg::DIST_W-1:0]       distance,
	output logic                              weight_error,
	output logic [wcdd_pkg::FRAME_W-1:0]      row_index,
	output logic [wcdd_pkg::FRAME_W-1:0]      col_index,
	input  logic                              cfg_we,
	input  logic [2:0]                        cfg_index,
	input  logic [wcdd_pkg::WGT_W-1:0]        cfg_data
);

	// Raw register values, as written
	logic [wcdd_pkg::WGT_W-1:0]   w_cep_q, w_energy_q, w_delta_q, w_delta_energy_q, scale_q;
	logic [wcdd_pkg::HALF_W-1:0]  half_q;
	logic [wcdd_pkg::FRAME_W-1:0] frames_a_q, frames_b_q;

	wcdd_pkg::cfg_t cfg;
	wcdd_pkg::cmd_t cmd;
	wcdd_pkg::sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_cep_q          <= 16'd256;
			w_energy_q       <= '0;
			w_delta_q        <= '0;
			w_delta_energy_q <= '0;
			half_q           <= 3'd1;
			frames_a_q       <= 9'd1;
			frames_b_q       <= 9'd1;
			scale_q          <= 16'd16384;
		end else if (cfg_we) begin
			case (cfg_index)
				wcdd_pkg::CFG_W_CEP:          w_cep_q <= cfg_data;
				wcdd_pkg::CFG_W_ENERGY:       w_energy_q <= cfg_data;
				wcdd_pkg::CFG_W_DELTA:        w_delta_q <= cfg_data;
				wcdd_pkg::CFG_W_DELTA_ENERGY: w_delta_energy_q <= cfg_data;
				wcdd_pkg::CFG_HALF_WINDOW:    half_q <= cfg_data[wcdd_pkg::HALF_W-1:0];
				wcdd_pkg::CFG_FRAMES_A:       frames_a_q <= cfg_data[wcdd_pkg::FRAME_W-1:0];
				wcdd_pkg::CFG_FRAMES_B:       frames_b_q <= cfg_data[wcdd_pkg::FRAME_W-1:0];
				wcdd_pkg::CFG_DELTA_SCALE:    scale_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Effective settings: clamp the half window to 1..max, frame counts to the store
	always_comb begin
		cfg.w_cep          = w_cep_q;
		cfg.w_energy       = w_energy_q;
		cfg.w_delta        = w_delta_q;
		cfg.w_delta_energy = w_delta_energy_q;
		cfg.scale          = scale_q;
		if (half_q == '0) begin
			cfg.half = wcdd_pkg::HALF_W'(1);
		end else if (half_q > wcdd_pkg::HALF_W'(wcdd_pkg::MAX_HALF_WINDOW)) begin
			cfg.half = wcdd_pkg::HALF_W'(wcdd_pkg::MAX_HALF_WINDOW);
		end else begin
			cfg.half = half_q;
		end
		cfg.na = (frames_a_q > wcdd_pkg::FRAME_W'(wcdd_pkg::MAX_FRAMES))
			? wcdd_pkg::FRAME_W'(wcdd_pkg::MAX_FRAMES) : frames_a_q;
		cfg.nb = (frames_b_q > wcdd_pkg::FRAME_W'(wcdd_pkg::MAX_FRAMES))
			? wcdd_pkg::FRAME_W'(wcdd_pkg::MAX_FRAMES) : frames_b_q;
	end

	wcdd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	wcdd_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.cmd               (cmd),
		.sts               (sts),
		.kind              (kind),
		.frame_index       (frame_index),
		.coef_index        (coef_index),
		.coef_value        (coef_value),
		.other_frame_index (other_frame_index),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.distance          (distance),
		.weight_error      (weight_error),
		.row_index         (row_index),
		.col_index         (col_index)
	);

endmodule

// ----- verif/weighted_cepstral_delta_distance_core_tb.sv -----
// Testbench for weighted_cepstral_delta_distance_core: directed table, then random loads
// and queries checked against an in-bench distance predictor. Uses wcdd_pkg and the core.
`timescale 1ns / 1ps

module weighted_cepstral_delta_distance_core_tb;
	import wcdd_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT  = 2_000_000;
	// Settling wait, chosen to outlast the longest query.
	localparam int SETTLE       = 250;
	localparam int NUM_PHASES   = 12;
	localparam int PHASE_ITEMS  = 70;
	localparam int LONG_HOLD    = 1500;

	typedef struct packed {
		logic [DIST_W-1:0]  distance;
		logic               err;
		logic [FRAME_W-1:0] row;
		logic [FRAME_W-1:0] col;
	} dist_t;

	// One row of stimulus: a register write or a request, with an optional typed result.
	typedef struct packed {
		logic               is_cfg;
		logic [2:0]         reg_idx;
		logic [1:0]         kind;
		logic [FRAME_W-1:0] fi;
		logic [COEF_W-1:0]  ci;
		logic [VAL_W-1:0]   val;
		logic [FRAME_W-1:0] fj;
		logic               typed;
		logic [DIST_W-1:0]  t_dist;
		logic               t_err;
	} step_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [1:0]                kind;
	logic [FRAME_W-1:0]        frame_index;
	logic [COEF_W-1:0]         coef_index;
	logic signed [VAL_W-1:0]   coef_value;
	logic [FRAME_W-1:0]        other_frame_index;
	logic                      out_valid;
	logic                      out_stall;
	logic [DIST_W-1:0]         distance;
	logic                      weight_error;
	logic [FRAME_W-1:0]        row_index;
	logic [FRAME_W-1:0]        col_index;
	logic                      cfg_we;
	logic [2:0]                cfg_index;
	logic [WGT_W-1:0]          cfg_data;

	// Shadow of the block: registers, both stores, and which entries were loaded.
	int unsigned reg_val [0:7];
	logic [VAL_W-1:0] store_a [0:STORE_DEPTH-1];
	logic [VAL_W-1:0] store_b [0:STORE_DEPTH-1];
	bit wr_a [0:STORE_DEPTH-1];
	bit wr_b [0:STORE_DEPTH-1];
	int dlt [0:1][0:NUM_COEFFS];

	dist_t exp_q [$];
	step_t dir_tab [$];
	int    errors;
	int    cycles;
	bit    quiet;
	bit    hold_req;

	weighted_cepstral_delta_distance_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .frame_index(frame_index), .coef_index(coef_index),
		.coef_value(coef_value), .other_frame_index(other_frame_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.distance(distance), .weight_error(weight_error),
		.row_index(row_index), .col_index(col_index),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic int eff_frames(int unsigned n);
		return (n > MAX_FRAMES) ? MAX_FRAMES : int'(n);
	endfunction

	// Half window 0 counts as 1, anything above the maximum as the maximum.
	function automatic int eff_half();
		if (reg_val[CFG_HALF_WINDOW] < 1) return 1;
		if (reg_val[CFG_HALF_WINDOW] > MAX_HALF_WINDOW) return MAX_HALF_WINDOW;
		return int'(reg_val[CFG_HALF_WINDOW]);
	endfunction

	function automatic int coef_at(bit sel_b, int f, int k);
		int idx;
		if (f < 1 || f > MAX_FRAMES) return 0;
		idx = (f - 1) * ROW_LEN + k;
		return sel_b ? int'($signed(store_b[idx])) : int'($signed(store_a[idx]));
	endfunction

	// Delta regression of every coefficient of frame f; zero near either end of the
	// sequence, keeping the asymmetric upper test (f >= n - h).
	function automatic void regress(bit sel_b, int f, int n);
		int h;
		longint s, p, mag;
		h = eff_half();
		for (int i = 0; i <= NUM_COEFFS; i++) dlt[sel_b][i] = 0;
		if (f <= h || f >= n - h) return;
		for (int i = 0; i <= NUM_COEFFS; i++) begin
			s = 0;
			for (int j = -h; j <= h; j++) s += longint'(coef_at(sel_b, f + j, i)) * j;
			p = s * longint'(reg_val[CFG_DELTA_SCALE]);
			mag = (p < 0) ? -p : p;
			mag = (mag + 32768) >> 16;
			if (p < 0) dlt[sel_b][i] = (mag > 32768) ? -32768 : -int'(mag);
			else dlt[sel_b][i] = (mag > 32767) ? 32767 : int'(mag);
		end
	endfunction

	function automatic dist_t predict_distance(int fi, int fj);
		dist_t r;
		longint unsigned s_cep, s_del, s_en, s_den, num, wsum, quo, root, t;
		longint d;
		regress(1'b0, fi, eff_frames(reg_val[CFG_FRAMES_A]));
		regress(1'b1, fj, eff_frames(reg_val[CFG_FRAMES_B]));
		s_cep = 0;
		s_del = 0;
		for (int k = 1; k <= NUM_COEFFS; k++) begin
			d = longint'(coef_at(1'b0, fi, k)) - coef_at(1'b1, fj, k);
			s_cep += longint'(d * d);
			d = longint'(dlt[0][k]) - dlt[1][k];
			s_del += longint'(d * d);
		end
		d = longint'(coef_at(1'b0, fi, 0)) - coef_at(1'b1, fj, 0);
		s_en = d * d;
		d = longint'(dlt[0][0]) - dlt[1][0];
		s_den = d * d;
		num = reg_val[CFG_W_CEP] * s_cep + reg_val[CFG_W_ENERGY] * s_en
			+ reg_val[CFG_W_DELTA] * s_del + reg_val[CFG_W_DELTA_ENERGY] * s_den;
		wsum = longint'(reg_val[CFG_W_CEP]) + reg_val[CFG_W_ENERGY]
			+ reg_val[CFG_W_DELTA] + reg_val[CFG_W_DELTA_ENERGY];
		r.row = FRAME_W'(fi);
		r.col = FRAME_W'(fj);
		if (wsum == 0) begin
			r.distance = '0;
			r.err = 1'b1;
		end else begin
			quo = num / (wsum * 256);
			root = 0;
			// Bitwise integer square root: keep each bit whose square still fits.
			for (int b = 31; b >= 0; b--) begin
				t = root | (64'd1 << b);
				if (t * t <= quo) root = t;
			end
			r.distance = (root > 65535) ? 16'hFFFF : DIST_W'(root);
			r.err = 1'b0;
		end
		return r;
	endfunction

	// True when a query of frame f reads only loaded entries.
	function automatic bit row_ok(bit sel_b, int f, int n);
		int h, lo, hi;
		h = eff_half();
		if (f < 1 || f > n) return 0;
		lo = f;
		hi = f;
		if (f > h && f < n - h) begin
			lo = f - h;
			hi = f + h;
		end
		for (int r = lo; r <= hi; r++)
			for (int k = 0; k <= NUM_COEFFS; k++)
				if (sel_b ? !wr_b[(r - 1) * ROW_LEN + k] : !wr_a[(r - 1) * ROW_LEN + k])
					return 0;
		return 1;
	endfunction

	// ---------------------------------------------------------------- stimulus rows

	function automatic step_t ld(logic [1:0] k, int fi, int ci, logic [VAL_W-1:0] v);
		step_t s;
		s = '0;
		s.kind = k;
		s.fi = FRAME_W'(fi);
		s.ci = COEF_W'(ci);
		s.val = v;
		s.fj = FRAME_W'($urandom);
		return s;
	endfunction

	function automatic step_t qy(int fi, int fj);
		step_t s;
		s = '0;
		s.kind = KIND_QUERY;
		s.fi = FRAME_W'(fi);
		s.fj = FRAME_W'(fj);
		s.ci = COEF_W'($urandom);
		s.val = VAL_W'($urandom);
		return s;
	endfunction

	function automatic step_t cf(cfg_idx_t idx, int unsigned v);
		step_t s;
		s = '0;
		s.is_cfg = 1'b1;
		s.reg_idx = idx;
		s.val = VAL_W'(v);
		return s;
	endfunction

	// Record an accepted request: update a store, or queue the distance it must produce.
	task automatic apply_req(step_t s);
		int idx;
		if (s.kind == KIND_LOAD_A || s.kind == KIND_LOAD_B) begin
			if (s.fi >= 1 && s.fi <= MAX_FRAMES && s.ci <= NUM_COEFFS) begin
				idx = (int'(s.fi) - 1) * ROW_LEN + int'(s.ci);
				if (s.kind == KIND_LOAD_A) begin
					store_a[idx] = s.val;
					wr_a[idx] = 1'b1;
				end else begin
					store_b[idx] = s.val;
					wr_b[idx] = 1'b1;
				end
			end
		end else if (s.kind == KIND_QUERY) begin
			if (s.fi >= 1 && s.fi <= eff_frames(reg_val[CFG_FRAMES_A])
					&& s.fj >= 1 && s.fj <= eff_frames(reg_val[CFG_FRAMES_B])) begin
				if (s.typed) exp_q.push_back('{s.t_dist, s.t_err, s.fi, s.fj});
				else exp_q.push_back(predict_distance(s.fi, s.fj));
			end
		end
	endtask

	// Offer one request. Valid stays high into the next request when no gap is drawn,
	// so it is never lowered and raised in the same step.
	task automatic send_req(step_t s);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= s.kind;
		frame_index <= s.fi;
		coef_index <= s.ci;
		coef_value <= s.val;
		other_frame_index <= s.fj;
		do @(posedge clk); while (in_stall);
		apply_req(s);
	endtask

	// Drain every pending result, then idle for a settling wait before any write.
	task automatic settle();
		in_valid <= 1'b0;
		while (exp_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, int unsigned v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= WGT_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_HALF_WINDOW: reg_val[idx] = v & 32'h7;
			CFG_FRAMES_A, CFG_FRAMES_B: reg_val[idx] = v & 32'h1FF;
			default: reg_val[idx] = v & 32'hFFFF;
		endcase
		@(posedge clk);
	endtask

	// Load every not yet written coefficient of frames lo..hi of one store.
	task automatic fill_rows(bit sel_b, int lo, int hi);
		for (int f = lo; f <= hi; f++)
			for (int k = 0; k <= NUM_COEFFS; k++)
				if (sel_b ? !wr_b[(f - 1) * ROW_LEN + k] : !wr_a[(f - 1) * ROW_LEN + k])
					send_req(ld(sel_b ? KIND_LOAD_B : KIND_LOAD_A, f, k, VAL_W'($urandom)));
	endtask

	task automatic fill_seq(bit sel_b, int n);
		if (n <= 16) begin
			fill_rows(sel_b, 1, n);
		end else begin
			fill_rows(sel_b, 1, 10);
			fill_rows(sel_b, n - 12, n);
		end
	endtask

	// Favor the loaded ends of a long sequence.
	function automatic int pick_frame(int n);
		if (n < 1) return 1;
		if ($urandom_range(0, 1)) return $urandom_range((n > 13) ? n - 12 : 1, n);
		return $urandom_range(1, (n < 10) ? n : 10);
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic int unsigned pick_weight();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 65535;
			2: return 256;
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	// Draw a well-formed query whose reads are all loaded; fall back to a load.
	task automatic random_query();
		int na, nb, fi, fj;
		bit ok_a, ok_b;
		na = eff_frames(reg_val[CFG_FRAMES_A]);
		nb = eff_frames(reg_val[CFG_FRAMES_B]);
		ok_a = 0;
		ok_b = 0;
		for (int t = 0; t < 40 && !ok_a; t++) begin
			fi = pick_frame(na);
			ok_a = row_ok(1'b0, fi, na);
		end
		for (int t = 0; t < 40 && !ok_b; t++) begin
			fj = pick_frame(nb);
			ok_b = row_ok(1'b1, fj, nb);
		end
		if (ok_a && ok_b) send_req(qy(fi, fj));
		else send_req(ld(KIND_LOAD_A, pick_frame(na), $urandom_range(0, NUM_COEFFS), pick_value()));
	endtask

	task automatic random_req();
		int r, n;
		r = $urandom_range(0, 99);
		n = eff_frames(reg_val[CFG_FRAMES_A]);
		if (r < 50) begin
			random_query();
		end else if (r < 85) begin
			send_req(ld($urandom_range(0, 1) ? KIND_LOAD_B : KIND_LOAD_A, pick_frame(n),
				$urandom_range(0, NUM_COEFFS), pick_value()));
		end else if (r < 90) begin
			// bad load: frame off the store or coefficient past the last
			if ($urandom_range(0, 1))
				send_req(ld(KIND_LOAD_A, $urandom_range(0, 1) ? 0 : $urandom_range(257, 511),
					$urandom_range(0, 15), pick_value()));
			else
				send_req(ld(KIND_LOAD_B, $urandom_range(1, 256), $urandom_range(13, 15),
					pick_value()));
		end else if (r < 95) begin
			send_req(ld(KIND_UNUSED, $urandom_range(0, 511), $urandom_range(0, 15), pick_value()));
		end else begin
			// query outside the configured sequence
			if ($urandom_range(0, 1)) send_req(qy($urandom_range(0, 1) ? 0 : $urandom_range(n + 1, 511),
				$urandom_range(0, 511)));
			else send_req(qy(1, $urandom_range(0, 1) ? 0 : $urandom_range(257, 511)));
		end
	endtask

	task automatic set_phase(int p);
		case (p)
			0: begin
				write_reg(CFG_W_CEP, 65535);
				write_reg(CFG_W_ENERGY, 65535);
				write_reg(CFG_W_DELTA, 65535);
				write_reg(CFG_W_DELTA_ENERGY, 65535);
				write_reg(CFG_HALF_WINDOW, 4);
				write_reg(CFG_FRAMES_A, 256);
				write_reg(CFG_FRAMES_B, 256);
				write_reg(CFG_DELTA_SCALE, 65535);
			end
			1: begin
				write_reg(CFG_W_CEP, 1);
				write_reg(CFG_W_ENERGY, 0);
				write_reg(CFG_W_DELTA, 65535);
				write_reg(CFG_W_DELTA_ENERGY, 1);
				write_reg(CFG_HALF_WINDOW, 7);
				write_reg(CFG_FRAMES_A, 300);
				write_reg(CFG_FRAMES_B, 511);
				write_reg(CFG_DELTA_SCALE, 0);
			end
			2: begin
				write_reg(CFG_HALF_WINDOW, 0);
				write_reg(CFG_FRAMES_A, 12);
				write_reg(CFG_FRAMES_B, 9);
				write_reg(CFG_DELTA_SCALE, 65535);
			end
			default: begin
				write_reg(CFG_W_CEP, pick_weight());
				write_reg(CFG_W_ENERGY, pick_weight());
				write_reg(CFG_W_DELTA, pick_weight());
				write_reg(CFG_W_DELTA_ENERGY, pick_weight());
				write_reg(CFG_HALF_WINDOW, $urandom_range(0, 7));
				write_reg(CFG_FRAMES_A, ($urandom_range(0, 9) == 0) ? 256 : $urandom_range(1, 16));
				write_reg(CFG_FRAMES_B, ($urandom_range(0, 9) == 0) ? 256 : $urandom_range(1, 16));
				write_reg(CFG_DELTA_SCALE, $urandom_range(0, 1) ? 16384 : $urandom_range(0, 65535));
			end
		endcase
	endtask

	// ---------------------------------------------------------------- result side

	task automatic check_result();
		dist_t e;
		if (exp_q.size() == 0) begin
			$error("unexpected result: distance %0d row %0d col %0d", distance, row_index,
				col_index);
			errors++;
			return;
		end
		e = exp_q.pop_front();
		if (distance !== e.distance) begin
			$error("distance: expected %0d, got %0d", e.distance, distance);
			errors++;
		end
		if (weight_error !== e.err) begin
			$error("weight_error: expected %0d, got %0d", e.err, weight_error);
			errors++;
		end
		if (row_index !== e.row) begin
			$error("row_index: expected %0d, got %0d", e.row, row_index);
			errors++;
		end
		if (col_index !== e.col) begin
			$error("col_index: expected %0d, got %0d", e.col, col_index);
			errors++;
		end
	endtask

	// Receiver: check each accepted result, then draw a stall for the next one.
	// A hold request from the sender side turns into one long stall, counted here.
	initial begin
		int stall_left;
		stall_left = 0;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				check_result();
				stall_left = quiet ? 0 : $urandom_range(0, 8);
			end
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end
			out_stall <= (stall_left != 0);
			if (stall_left != 0) stall_left--;
		end
	end

	// ---------------------------------------------------------------- main sequence

	initial begin
		step_t s;
		errors = 0;
		cycles = 0;
		quiet = 0;
		hold_req = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_LOAD_A;
		frame_index = '0;
		coef_index = '0;
		coef_value = '0;
		other_frame_index = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_W_CEP;
		cfg_data = '0;
		reg_val = '{256, 0, 0, 0, 1, 1, 1, 16384};
		for (int i = 0; i < STORE_DEPTH; i++) begin
			store_a[i] = '0;
			store_b[i] = '0;
			wr_a[i] = 1'b0;
			wr_b[i] = 1'b0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Frame 1 of both stores must be loaded before any query reads it.
		fill_rows(1'b0, 1, 1);
		fill_rows(1'b1, 1, 1);

		// Directed part, reset settings: one frame per sequence, cepstral weight only.
		dir_tab.push_back(ld(KIND_LOAD_A, 1, 0, 16'h8000));
		dir_tab.push_back(ld(KIND_LOAD_A, 1, NUM_COEFFS, 16'h7FFF));
		dir_tab.push_back(ld(KIND_LOAD_B, 1, 0, 16'h7FFF));
		dir_tab.push_back(ld(KIND_LOAD_B, 1, NUM_COEFFS, 16'h8000));
		dir_tab.push_back(qy(1, 1));
		// loads that must be dropped
		dir_tab.push_back(ld(KIND_LOAD_A, 0, 0, 16'h1234));
		dir_tab.push_back(ld(KIND_LOAD_B, 257, 0, 16'h1234));
		dir_tab.push_back(ld(KIND_LOAD_A, 1, 13, 16'hFFFF));
		dir_tab.push_back(ld(KIND_LOAD_B, 511, 15, 16'h0000));
		dir_tab.push_back(ld(KIND_UNUSED, 511, 15, 16'hFFFF));
		// queries outside the sequences give nothing
		dir_tab.push_back(qy(2, 1));
		dir_tab.push_back(qy(1, 0));
		dir_tab.push_back(qy(0, 511));
		// zero weight sum: flag set, distance zero
		dir_tab.push_back(cf(CFG_W_CEP, 0));
		s = qy(1, 1);
		s.typed = 1'b1;
		s.t_dist = '0;
		s.t_err = 1'b1;
		dir_tab.push_back(s);
		dir_tab.push_back(cf(CFG_W_ENERGY, 65535));
		dir_tab.push_back(qy(1, 1));
		dir_tab.push_back(cf(CFG_W_CEP, 65535));
		dir_tab.push_back(cf(CFG_W_DELTA, 65535));
		dir_tab.push_back(cf(CFG_W_DELTA_ENERGY, 65535));
		dir_tab.push_back(qy(1, 1));
		// no valid frame at all
		dir_tab.push_back(cf(CFG_FRAMES_A, 0));
		dir_tab.push_back(qy(1, 1));
		dir_tab.push_back(cf(CFG_FRAMES_A, 1));

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				settle();
				write_reg(cfg_idx_t'(dir_tab[i].reg_idx), dir_tab[i].val);
			end else begin
				send_req(dir_tab[i]);
			end
		end

		// Random part: one setting per phase, written only once the block is idle.
		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			set_phase(p);
			quiet = (p == 4);
			fill_seq(1'b0, eff_frames(reg_val[CFG_FRAMES_A]));
			fill_seq(1'b1, eff_frames(reg_val[CFG_FRAMES_B]));
			if (p == 5) begin
				// Block the output for a long stretch; queries pile up and stall the input.
				hold_req = 1'b1;
				repeat (6) random_query();
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 6 && n == PHASE_ITEMS / 2) begin
					// Pause the sender until every pending distance is back.
					in_valid <= 1'b0;
					while (exp_q.size() != 0) @(posedge clk);
				end
				random_req();
			end
		end
		quiet = 0;

		settle();
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
